// ----- hw/rtl/lcpv_pkg.sv -----
// ----------------------------------------------------------------------------
// lcpv_pkg: shared types and constants of the lamp color pixel vote
// Pixel, class, tally and configuration types, classing margins and the
// register reset values.
// ----------------------------------------------------------------------------
package lcpv_pkg;

   localparam int CH_W     = 8;
   localparam int WEIGHT_W = 3;
   localparam int LIT_W    = 17;
   localparam int VOTE_W   = 18;
   localparam int TOTAL_W  = 20;
   localparam int CSR_IDX_W = 3;

   // Pixel classing margins, compared on 9-bit values.
   localparam logic [8:0] RED_MARGIN         = 9'd25;
   localparam logic [8:0] GREEN_RED_MARGIN   = 9'd25;
   localparam logic [8:0] GREEN_BLUE_MARGIN  = 9'd20;
   localparam logic [8:0] YELLOW_BLUE_MARGIN = 9'd30;
   localparam logic [8:0] YELLOW_RG_SPAN     = 9'd40;

   // Hue windows, in two-degree units.
   localparam logic [7:0] HUE_MAX         = 8'd180;
   localparam logic [7:0] HUE_RED_LOW     = 8'd12;
   localparam logic [7:0] HUE_RED_HIGH    = 8'd155;
   localparam logic [7:0] HUE_YELLOW_LOW  = 8'd13;
   localparam logic [7:0] HUE_YELLOW_HIGH = 8'd38;
   localparam logic [7:0] HUE_GREEN_LOW   = 8'd50;
   localparam logic [7:0] HUE_GREEN_HIGH  = 8'd80;

   // Register reset values.
   localparam logic [7:0]          RST_PRIMARY   = 8'd160;
   localparam logic [7:0]          RST_FALLBACK  = 8'd100;
   localparam logic [7:0]          RST_STRONG    = 8'd220;
   localparam logic [WEIGHT_W-1:0] RST_WEIGHT    = 3'd3;
   localparam logic [7:0]          RST_MIN_SAT   = 8'd40;
   localparam logic [7:0]          RST_MIN_LIT   = 8'd3;
   localparam logic [7:0]          RST_MIN_VOTES = 8'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PRIMARY   = 3'd0,
      REG_FALLBACK  = 3'd1,
      REG_STRONG    = 3'd2,
      REG_WEIGHT    = 3'd3,
      REG_MIN_SAT   = 3'd4,
      REG_MIN_LIT   = 3'd5,
      REG_MIN_VOTES = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      CLS_RED    = 2'd0,
      CLS_YELLOW = 2'd1,
      CLS_GREEN  = 2'd2,
      CLS_NONE   = 2'd3
   } class_code_type;

   typedef enum logic [1:0] {
      COLOR_UNKNOWN = 2'd0,
      COLOR_RED     = 2'd1,
      COLOR_YELLOW  = 2'd2,
      COLOR_GREEN   = 2'd3
   } lamp_color_type;

   typedef struct packed {
      logic [7:0]          primary;
      logic [7:0]          fallback;
      logic [7:0]          strong_level;
      logic [WEIGHT_W-1:0] weight;
      logic [7:0]          min_sat;
      logic [7:0]          min_lit;
      logic [7:0]          min_votes;
   } cfg_type;

   typedef struct packed {
      logic [CH_W-1:0] hue;
      logic [CH_W-1:0] saturation;
      logic [CH_W-1:0] brightness;
      logic [CH_W-1:0] blue_level;
      logic [CH_W-1:0] green_level;
      logic [CH_W-1:0] red_level;
      logic            last_pixel;
   } pixel_type;

   typedef struct packed {
      logic                lit_primary;
      logic                lit_fallback;
      class_code_type      cls;
      logic [WEIGHT_W-1:0] weight;
      logic                last_pixel;
   } class_type;

   typedef struct packed {
      logic [LIT_W-1:0]  lit;
      logic [VOTE_W-1:0] red;
      logic [VOTE_W-1:0] yellow;
      logic [VOTE_W-1:0] green;
   } tally_type;

endpackage

// ----- hw/rtl/lcpv_classify.sv -----
// ----------------------------------------------------------------------------
// lcpv_classify: per-pixel classing
// Decides lit flags for both levels, the color class and the vote weight.
// ----------------------------------------------------------------------------
module lcpv_classify (
   input  lcpv_pkg::pixel_type pix,
   input  lcpv_pkg::cfg_type   cfg,
   output lcpv_pkg::class_type cls
);

   logic [8:0] r9, g9, b9, rg_diff;
   logic       hue_ok, sat_ok;
   logic       rgb_red, rgb_green, rgb_yellow;
   logic       hue_red, hue_yellow, hue_green;
   lcpv_pkg::class_code_type code;

   assign r9 = {1'b0, pix.red_level};
   assign g9 = {1'b0, pix.green_level};
   assign b9 = {1'b0, pix.blue_level};
   assign rg_diff = (r9 >= g9) ? (r9 - g9) : (g9 - r9);

   assign hue_ok = pix.hue <= lcpv_pkg::HUE_MAX;
   assign sat_ok = pix.saturation >= cfg.min_sat;

   assign rgb_red    = (r9 > g9 + lcpv_pkg::RED_MARGIN) && (r9 > b9 + lcpv_pkg::RED_MARGIN);
   assign rgb_green  = (g9 > r9 + lcpv_pkg::GREEN_RED_MARGIN)
                    && (g9 > b9 + lcpv_pkg::GREEN_BLUE_MARGIN);
   assign rgb_yellow = (rg_diff < lcpv_pkg::YELLOW_RG_SPAN)
                    && (r9 > b9 + lcpv_pkg::YELLOW_BLUE_MARGIN)
                    && (g9 > b9 + lcpv_pkg::YELLOW_BLUE_MARGIN);

   assign hue_red    = (pix.hue <= lcpv_pkg::HUE_RED_LOW) || (pix.hue >= lcpv_pkg::HUE_RED_HIGH);
   assign hue_yellow = (pix.hue >= lcpv_pkg::HUE_YELLOW_LOW)
                    && (pix.hue <= lcpv_pkg::HUE_YELLOW_HIGH);
   assign hue_green  = (pix.hue >= lcpv_pkg::HUE_GREEN_LOW)
                    && (pix.hue <= lcpv_pkg::HUE_GREEN_HIGH);

   // RGB margins first, then hue when saturated enough.
   always_comb begin
      priority if (rgb_red) begin
         code = lcpv_pkg::CLS_RED;
      end else if (rgb_green) begin
         code = lcpv_pkg::CLS_GREEN;
      end else if (rgb_yellow) begin
         code = lcpv_pkg::CLS_YELLOW;
      end else if (sat_ok && hue_red) begin
         code = lcpv_pkg::CLS_RED;
      end else if (sat_ok && hue_yellow) begin
         code = lcpv_pkg::CLS_YELLOW;
      end else if (sat_ok && hue_green) begin
         code = lcpv_pkg::CLS_GREEN;
      end else begin
         code = lcpv_pkg::CLS_NONE;
      end
   end

   assign cls.lit_primary  = hue_ok && (pix.brightness >= cfg.primary);
   assign cls.lit_fallback = hue_ok && (pix.brightness >= cfg.fallback);
   assign cls.cls          = code;
   assign cls.weight       = (pix.brightness > cfg.strong_level) ? cfg.weight
                                                                 : lcpv_pkg::WEIGHT_W'(1);
   assign cls.last_pixel   = pix.last_pixel;

endmodule

// ----- hw/rtl/lcpv_tally.sv -----
// ----------------------------------------------------------------------------
// lcpv_tally: primary and fallback tally sets
// Accumulates saturating counts; on the last pixel picks a set into the
// snapshot register and clears both sets.
// ----------------------------------------------------------------------------
module lcpv_tally (
   input  logic                clock,
   input  logic                reset,
   input  logic                cls_valid,
   input  lcpv_pkg::class_type cls,
   input  logic [7:0]          min_lit,
   input  logic                snap_ready,
   output logic                cls_take,
   output logic                snap_valid,
   output lcpv_pkg::tally_type snap
);

   lcpv_pkg::tally_type prim_ff, prim_in, fall_ff, fall_in, snap_ff, snap_in;
   lcpv_pkg::tally_type prim_new, fall_new;
   logic                snap_valid_ff, snap_valid_in;
   logic                snap_load;

   function automatic logic [lcpv_pkg::VOTE_W-1:0] vote_add(
      input logic [lcpv_pkg::VOTE_W-1:0]   v,
      input logic [lcpv_pkg::WEIGHT_W-1:0] w
   );
      logic [lcpv_pkg::VOTE_W:0] sum;
      sum = {1'b0, v} + {{(lcpv_pkg::VOTE_W+1-lcpv_pkg::WEIGHT_W){1'b0}}, w};
      return sum[lcpv_pkg::VOTE_W] ? '1 : sum[lcpv_pkg::VOTE_W-1:0];
   endfunction

   function automatic lcpv_pkg::tally_type add_pixel(
      input lcpv_pkg::tally_type t,
      input logic                hit,
      input lcpv_pkg::class_type c
   );
      lcpv_pkg::tally_type r;
      r = t;
      if (hit) begin
         if (t.lit != '1) begin
            r.lit = t.lit + lcpv_pkg::LIT_W'(1);
         end
         unique case (c.cls)
            lcpv_pkg::CLS_RED:    r.red    = vote_add(t.red, c.weight);
            lcpv_pkg::CLS_YELLOW: r.yellow = vote_add(t.yellow, c.weight);
            lcpv_pkg::CLS_GREEN:  r.green  = vote_add(t.green, c.weight);
            default:              r = r;
         endcase
      end
      return r;
   endfunction

   assign prim_new = add_pixel(prim_ff, cls.lit_primary, cls);
   assign fall_new = add_pixel(fall_ff, cls.lit_fallback, cls);

   // A last pixel waits only while the snapshot is held.
   assign cls_take  = cls_valid && (!cls.last_pixel || !snap_valid_ff || snap_ready);
   assign snap_load = cls_take && cls.last_pixel;

   always_comb begin
      prim_in = prim_ff;
      fall_in = fall_ff;
      if (cls_take) begin
         prim_in = cls.last_pixel ? '0 : prim_new;
         fall_in = cls.last_pixel ? '0 : fall_new;
      end
   end

   always_comb begin
      snap_in = snap_ff;
      if (snap_load) begin
         priority if (prim_new.lit >= {{(lcpv_pkg::LIT_W-8){1'b0}}, min_lit}) begin
            snap_in = prim_new;
         end else if (fall_new.lit >= {{(lcpv_pkg::LIT_W-8){1'b0}}, min_lit}) begin
            snap_in = fall_new;
         end else begin
            snap_in = '0;
         end
      end
   end

   assign snap_valid_in = snap_load ? 1'b1 : (snap_valid_ff && !snap_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         prim_ff       <= '0;
         fall_ff       <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         prim_ff       <= prim_in;
         fall_ff       <= fall_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

// ----- hw/rtl/lcpv_verdict.sv -----
// ----------------------------------------------------------------------------
// lcpv_verdict: color decision and result register
// Checks the vote total, picks the winner and holds the result item.
// ----------------------------------------------------------------------------
module lcpv_verdict (
   input  logic                clock,
   input  logic                reset,
   input  logic                snap_valid,
   input  lcpv_pkg::tally_type snap,
   input  logic [7:0]          min_votes,
   output logic                snap_ready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [79:0]         rsp_tdata
);

   logic [lcpv_pkg::TOTAL_W-1:0] total;
   logic                         enough;
   lcpv_pkg::lamp_color_type     color;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [79:0]                  rsp_data_ff, rsp_data_in;
   logic                         load;

   assign total = {2'b00, snap.red} + {2'b00, snap.yellow} + {2'b00, snap.green};
   assign enough = total >= {{(lcpv_pkg::TOTAL_W-8){1'b0}}, min_votes};

   // Ties go red, then yellow, then green.
   always_comb begin
      priority if (!enough) begin
         color = lcpv_pkg::COLOR_UNKNOWN;
      end else if (snap.red >= snap.yellow && snap.red >= snap.green && snap.red != '0) begin
         color = lcpv_pkg::COLOR_RED;
      end else if (snap.yellow >= snap.red && snap.yellow >= snap.green
                   && snap.yellow != '0) begin
         color = lcpv_pkg::COLOR_YELLOW;
      end else if (snap.green != '0) begin
         color = lcpv_pkg::COLOR_GREEN;
      end else begin
         color = lcpv_pkg::COLOR_UNKNOWN;
      end
   end

   assign snap_ready   = !rsp_valid_ff || rsp_tready;
   assign load         = snap_valid && snap_ready;
   assign rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   assign rsp_data_in  = load ? {7'b0, snap.lit, snap.green, snap.yellow, snap.red, color}
                              : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- hw/rtl/lamp_color_pixel_vote_core.sv -----
// ----------------------------------------------------------------------------
// lamp_color_pixel_vote_core: lamp color vote over one region of pixels
// Votes each lit pixel red, yellow or green in two brightness tally sets and
// gives one color verdict per region.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one pixel per item; req_tlast marks the last pixel of a
//          region. One item is taken per cycle as long as the pipe moves.
//   rsp_*  carries one verdict item per region, produced by its last pixel;
//          other pixels give no item.
//   csr_*  writes one register per handshake (index, 8-bit data); csr_ready
//          is always high. Write only while no region is in flight.
//   Path: the last pixel passes the input register, class register, tally
//   snapshot and result register before its verdict shows on rsp_tvalid.
//   Throughput is one pixel per cycle while nothing stalls.
//   Stall: while a verdict waits in the result register, pixels keep flowing
//   and accumulating; only a second last pixel backs up behind the snapshot,
//   and then the whole pipe holds and req_tready drops.
//   Reset: registers go to their reset values, tallies clear, the pipe
//   empties.
// ----------------------------------------------------------------------------
module lamp_color_pixel_vote_core (
   input  logic        clock,
   input  logic        reset,
   // hue[7:0], saturation[15:8], brightness[23:16], blue_level[31:24],
   // green_level[39:32], red_level[47:40]
   input  logic [47:0] req_tdata,
   input  logic        req_tlast,
   input  logic        req_tvalid,
   output logic        req_tready,
   // lamp_color[1:0], red_votes[19:2], yellow_votes[37:20],
   // green_votes[55:38], lit_pixels[72:56], zeros above
   output logic [79:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);

   lcpv_pkg::cfg_type   cfg_ff, cfg_in;
   lcpv_pkg::pixel_type pix_ff, pix_in;
   lcpv_pkg::class_type cls_ff, cls_in, cls_comb;
   lcpv_pkg::tally_type snap;
   logic                s1_valid_ff, s1_valid_in;
   logic                s2_valid_ff, s2_valid_in;
   logic                s2_free, cls_take;
   logic                snap_valid, snap_ready;
   logic                req_take;

   // Configuration: always ready, out-of-range index drops the write.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            lcpv_pkg::REG_PRIMARY:   cfg_in.primary      = csr_data;
            lcpv_pkg::REG_FALLBACK:  cfg_in.fallback     = csr_data;
            lcpv_pkg::REG_STRONG:    cfg_in.strong_level = csr_data;
            lcpv_pkg::REG_WEIGHT:    cfg_in.weight       = csr_data[lcpv_pkg::WEIGHT_W-1:0];
            lcpv_pkg::REG_MIN_SAT:   cfg_in.min_sat      = csr_data;
            lcpv_pkg::REG_MIN_LIT:   cfg_in.min_lit      = csr_data;
            lcpv_pkg::REG_MIN_VOTES: cfg_in.min_votes    = csr_data;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.primary      <= lcpv_pkg::RST_PRIMARY;
         cfg_ff.fallback     <= lcpv_pkg::RST_FALLBACK;
         cfg_ff.strong_level <= lcpv_pkg::RST_STRONG;
         cfg_ff.weight       <= lcpv_pkg::RST_WEIGHT;
         cfg_ff.min_sat      <= lcpv_pkg::RST_MIN_SAT;
         cfg_ff.min_lit      <= lcpv_pkg::RST_MIN_LIT;
         cfg_ff.min_votes    <= lcpv_pkg::RST_MIN_VOTES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Stage 1: input register. Advance whenever stage 2 frees up.
   assign s2_free    = !s2_valid_ff || cls_take;
   assign req_tready = !s1_valid_ff || s2_free;
   assign req_take   = req_tvalid && req_tready;

   assign pix_in = req_take ? {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16],
                               req_tdata[31:24], req_tdata[39:32], req_tdata[47:40],
                               req_tlast}
                            : pix_ff;
   assign s1_valid_in = req_take ? 1'b1 : (s1_valid_ff && !s2_free);

   // Stage 2: class register.
   lcpv_classify u_classify (
      .pix (pix_ff),
      .cfg (cfg_ff),
      .cls (cls_comb)
   );

   assign cls_in      = (s2_free && s1_valid_ff) ? cls_comb : cls_ff;
   assign s2_valid_in = s2_free ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
      cls_ff <= cls_in;
   end

   // Stage 3: tallies and per-region snapshot.
   lcpv_tally u_tally (
      .clock      (clock),
      .reset      (reset),
      .cls_valid  (s2_valid_ff),
      .cls        (cls_ff),
      .min_lit    (cfg_ff.min_lit),
      .snap_ready (snap_ready),
      .cls_take   (cls_take),
      .snap_valid (snap_valid),
      .snap       (snap)
   );

   // Stage 4: verdict into the result register.
   lcpv_verdict u_verdict (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap       (snap),
      .min_votes  (cfg_ff.min_votes),
      .snap_ready (snap_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- hw/rtl/lcpv_checker.sv -----
// ----------------------------------------------------------------------------
// lcpv_checker: port-level checks of the lamp color pixel vote
// Watches the result channel for hold, reset and verdict consistency.
// ----------------------------------------------------------------------------
module lcpv_checker (
   input logic        clock,
   input logic        reset,
   input logic [79:0] rsp_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready
);

   logic [1:0]  color;
   logic [17:0] red_v, yellow_v, green_v;
   logic [16:0] lit;

   assign color    = rsp_tdata[1:0];
   assign red_v    = rsp_tdata[19:2];
   assign yellow_v = rsp_tdata[37:20];
   assign green_v  = rsp_tdata[55:38];
   assign lit      = rsp_tdata[72:56];

   // Hold a stalled item unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result item changed");

   // No item right after reset.
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // A color verdict needs lit pixels.
   a_color_lit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && color != lcpv_pkg::COLOR_UNKNOWN |-> lit != '0)
      else $error("color verdict without lit pixels");

   // Red wins only as the largest tally.
   a_red_wins: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && color == lcpv_pkg::COLOR_RED |-> red_v >= yellow_v && red_v >= green_v)
      else $error("red verdict without largest red tally");

endmodule

bind lamp_color_pixel_vote_core lcpv_checker u_lcpv_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
